>>> sv/gradient_noise_2d_eval_core_assert.svh
// assertion macros used by the checker
`ifndef GRADIENT_NOISE_2D_EVAL_CORE_ASSERT_SVH
`define GRADIENT_NOISE_2D_EVAL_CORE_ASSERT_SVH

// same-cycle implication
`define GN2D_ASSERT_IMP(name, ck, rs, ante, cons) \
  name: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("gn2d check failed");

// next-cycle implication
`define GN2D_ASSERT_NXT(name, ck, rs, ante, cons) \
  name: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("gn2d check failed");

`endif

>>> sv/gn2d_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package gn2d_pkg;

  localparam int POS_W    = 22;
  localparam int GRAD_W   = 16;
  localparam int NOISE_W  = 16;
  localparam int ENT_W    = 2 * GRAD_W + 1;
  localparam int S_DATA_W = 80;
  localparam int M_DATA_W = 16;

  // fade 6t^5 - 15t^4 + 10t^3
  localparam int FADE_A = 6;
  localparam int FADE_B = 15;
  localparam int FADE_C = 10;

  localparam int SAT_MAX = 32767;
  localparam int SAT_MIN = -32768;

  typedef enum logic {
    FUNC_WRITE = 1'b0,
    FUNC_EVAL  = 1'b1
  } func_t;

endpackage
`default_nettype wire

>>> sv/gradient_noise_2d_eval_core.sv
// channel  dir  beat contents (low bits first)
// s_*      in   tdata: pos_x[21:0] pos_y[43:22] grad_x[59:44] grad_y[75:60]; tuser: func
// m_*      out  tdata: noise_value[15:0]; tuser: missing_gradient
//
// one beat per cycle unless m_tready stalls the pipeline or the valid bits are being cleared
// the gradient grid sits in four parity banks so all corners are read in the same cycle
// after reset s_tready stays low for one sweep over all 2^(bank address bits)
// addresses of a bank (1024 with the default grid), while the valid bits are cleared
// a stall on m_tready holds the whole pipeline; nothing is dropped or repeated
`timescale 1ns / 1ps
`default_nettype none
module gradient_noise_2d_eval_core #(
  parameter int GRID_WIDTH    = 64,
  parameter int GRID_HEIGHT   = 64,
  parameter int FRACTION_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [gn2d_pkg::S_DATA_W-1:0] s_tdata,  // pos_x, pos_y, grad_x, grad_y, zero pad
  input  logic                          s_tuser,  // func
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [gn2d_pkg::M_DATA_W-1:0] m_tdata,  // noise_value
  output logic                          m_tuser   // missing_gradient
);
  import gn2d_pkg::*;

  localparam int F    = FRACTION_BITS;
  localparam int IW   = (F < POS_W) ? POS_W - F : 1;
  localparam int BCW0 = $clog2((GRID_WIDTH + 1) / 2);
  localparam int BRW0 = $clog2((GRID_HEIGHT + 1) / 2);
  localparam int BCW  = (BCW0 < 1) ? 1 : BCW0;
  localparam int BRW  = (BRW0 < 1) ? 1 : BRW0;
  localparam int BAW  = BCW + BRW;
  localparam int BDEPTH = 1 << BAW;
  localparam int XW   = (IW + 1 > BCW + 1) ? IW + 1 : BCW + 1;
  localparam int YW   = (IW + 1 > BRW + 1) ? IW + 1 : BRW + 1;
  localparam int DW   = F + 1;
  localparam int PW   = F + 17;
  localparam int AW   = F + 5;
  localparam int TAW  = 2 * F + 6;
  localparam int TTW  = 2 * F + 2;
  localparam int NW   = 18;
  localparam int BW   = F + 6;
  localparam int T2W  = F + 3;
  localparam int T3PW = 2 * F + 4;
  localparam int SPW  = 2 * F + 9;
  localparam int SW   = F + 3;
  localparam int EW   = NW + SW;
  localparam int XNW  = 20;
  localparam int QW   = XNW + SW;

  function automatic logic signed [63:0] rnd(input logic signed [63:0] v);
    rnd = (v + (64'sd1 <<< (F - 1))) >>> F;
  endfunction

  logic adv, accept, clearing;
  logic [BAW-1:0] clr_cnt;

  logic [POS_W-1:0] px_in, py_in;
  logic [GRAD_W-1:0] gx_in, gy_in;
  func_t func_in;
  logic [IW-1:0] ix, iy;
  logic [F-1:0] fx_in, fy_in;
  logic [XW-1:0] ixw;
  logic [YW-1:0] iyw;
  logic off_x0, off_x1, off_y0, off_y1;
  logic [BAW-1:0] raddr [4];
  logic [3:0] we;
  logic [BAW-1:0] waddr;
  logic [ENT_W-1:0] wdata;
  logic [ENT_W-1:0] rd [4];

  // stage registers
  logic v1, v2, v3, v4, v5, v6, v7;
  logic eval1, ix0_1, iy0_1;
  logic [1:0] offx1, offy1;
  logic [F-1:0] fx1, fy1;

  logic signed [PW-1:0] pxc [4];
  logic signed [PW-1:0] pyc [4];
  logic miss_c;
  logic signed [TAW-1:0] ta_c [2];
  logic signed [TTW-1:0] tt_c [2];

  logic miss2, zero2;
  logic signed [PW-1:0] px2 [4];
  logic signed [PW-1:0] py2 [4];
  logic signed [TAW-1:0] ta2 [2];
  logic signed [TTW-1:0] tt2 [2];
  logic [F-1:0] t_2 [2];

  logic signed [NW-1:0] n_c [4];
  logic signed [BW-1:0] b_c [2];
  logic signed [T3PW-1:0] t3p_c [2];

  logic miss3, zero3;
  logic signed [NW-1:0] n3 [4];
  logic signed [BW-1:0] b3 [2];
  logic signed [T3PW-1:0] t3p3 [2];

  logic signed [SPW-1:0] sp_c [2];

  logic miss4, zero4;
  logic signed [NW-1:0] n4 [4];
  logic signed [SPW-1:0] sp4 [2];

  logic signed [SW-1:0] s_c [2];
  logic signed [SW-1:0] oms_c [2];
  logic signed [EW-1:0] e_c [4];

  logic miss5, zero5;
  logic signed [EW-1:0] e5 [4];
  logic signed [SW-1:0] sy5, omsy5;

  logic signed [XNW-1:0] nx_c [2];

  logic miss6, zero6;
  logic signed [XNW-1:0] nx6 [2];
  logic signed [SW-1:0] sy6, omsy6;

  logic signed [QW-1:0] q_c [2];

  logic miss7, zero7;
  logic signed [QW-1:0] q7 [2];

  logic signed [63:0] v_c;
  logic [NOISE_W-1:0] noise_c;

  // handshake
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv && !clearing;
  assign accept   = s_tvalid && s_tready;

  // input unpack
  assign px_in   = s_tdata[POS_W-1:0];
  assign py_in   = s_tdata[2*POS_W-1:POS_W];
  assign gx_in   = s_tdata[2*POS_W+GRAD_W-1:2*POS_W];
  assign gy_in   = s_tdata[2*POS_W+2*GRAD_W-1:2*POS_W+GRAD_W];
  assign func_in = func_t'(s_tuser);

  assign ix    = IW'(32'(px_in) >> F);
  assign iy    = IW'(32'(py_in) >> F);
  assign fx_in = F'(32'(px_in));
  assign fy_in = F'(32'(py_in));
  assign ixw   = XW'(ix);
  assign iyw   = YW'(iy);

  assign off_x0 = 32'(ix) >= GRID_WIDTH;
  assign off_x1 = 32'(ix) + 32'd1 >= GRID_WIDTH;
  assign off_y0 = 32'(iy) >= GRID_HEIGHT;
  assign off_y1 = 32'(iy) + 32'd1 >= GRID_HEIGHT;

  // valid bit clearing sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_cnt  <= '0;
    end else if (clearing) begin
      clr_cnt <= clr_cnt + BAW'(1);
      if (&clr_cnt) clearing <= 1'b0;
    end
  end

  // bank addressing
  always_comb begin
    logic [XW-1:0] cx;
    logic [YW-1:0] cy;
    for (int b = 0; b < 4; b++) begin
      cx = ixw + XW'(ix[0] != 1'(b));
      cy = iyw + YW'(iy[0] != 1'(b >> 1));
      raddr[b] = {cy[BRW:1], cx[BCW:1]};
      we[b] = clearing || (accept && func_in == FUNC_WRITE && !off_x0 && !off_y0 &&
              {iy[0], ix[0]} == 2'(b));
    end
    waddr = clearing ? clr_cnt : {iyw[BRW:1], ixw[BCW:1]};
    wdata = clearing ? '0 : {1'b1, gy_in, gx_in};
  end

  for (genvar gb = 0; gb < 4; gb++) begin : g_bank
    logic [ENT_W-1:0] mem [BDEPTH];
    always_ff @(posedge clk) begin
      if (we[gb]) mem[waddr] <= wdata;
      if (accept) rd[gb] <= mem[raddr[gb]];
    end
  end

  // corner products, missing check, first fade products
  always_comb begin
    logic [1:0] bk;
    logic [ENT_W-1:0] g;
    logic signed [DW-1:0] dx, dy;
    logic signed [AW-1:0] ts, a;
    miss_c = 1'b0;
    for (int c = 0; c < 4; c++) begin
      bk = {iy0_1 ^ 1'(c >> 1), ix0_1 ^ 1'(c)};
      g  = rd[bk];
      dx = $signed({1'(c), fx1});
      dy = $signed({1'(c >> 1), fy1});
      pxc[c] = PW'($signed(g[GRAD_W-1:0])) * PW'(dx);
      pyc[c] = PW'($signed(g[2*GRAD_W-1:GRAD_W])) * PW'(dy);
      miss_c = miss_c | offx1[1'(c)] | offy1[1'(c >> 1)] | !g[ENT_W-1];
    end
    for (int k = 0; k < 2; k++) begin
      ts = AW'($signed({1'b0, (k == 0) ? fx1 : fy1}));
      a  = (AW'(FADE_B) <<< F) - AW'(FADE_A) * ts;
      ta_c[k] = TAW'(ts) * TAW'(a);
      tt_c[k] = TTW'(ts) * TTW'(ts);
    end
  end

  // corner dots, fade middle terms
  always_comb begin
    logic signed [T2W-1:0] t2;
    for (int c = 0; c < 4; c++) begin
      n_c[c] = NW'(rnd(64'(px2[c]) + 64'(py2[c])));
    end
    for (int k = 0; k < 2; k++) begin
      b_c[k]   = (BW'(FADE_C) <<< F) - BW'(rnd(64'(ta2[k])));
      t2       = T2W'(rnd(64'(tt2[k])));
      t3p_c[k] = T3PW'(t2) * T3PW'($signed({1'b0, t_2[k]}));
    end
  end

  always_comb begin
    logic signed [T2W-1:0] t3;
    for (int k = 0; k < 2; k++) begin
      t3      = T2W'(rnd(64'(t3p3[k])));
      sp_c[k] = SPW'(t3) * SPW'(b3[k]);
    end
  end

  // fade result and x blend products
  always_comb begin
    for (int k = 0; k < 2; k++) begin
      s_c[k]   = SW'(rnd(64'(sp4[k])));
      oms_c[k] = (SW'(1) <<< F) - s_c[k];
    end
    e_c[0] = EW'(n4[0]) * EW'(oms_c[0]);
    e_c[1] = EW'(n4[1]) * EW'(s_c[0]);
    e_c[2] = EW'(n4[2]) * EW'(oms_c[0]);
    e_c[3] = EW'(n4[3]) * EW'(s_c[0]);
  end

  assign nx_c[0] = XNW'(rnd(64'(e5[0]) + 64'(e5[1])));
  assign nx_c[1] = XNW'(rnd(64'(e5[2]) + 64'(e5[3])));

  assign q_c[0] = QW'(nx6[0]) * QW'(omsy6);
  assign q_c[1] = QW'(nx6[1]) * QW'(sy6);

  always_comb begin
    v_c = rnd(64'(q7[0]) + 64'(q7[1]));
    if (v_c > 64'(SAT_MAX)) noise_c = NOISE_W'(SAT_MAX);
    else if (v_c < 64'(SAT_MIN)) noise_c = NOISE_W'(SAT_MIN);
    else noise_c = v_c[NOISE_W-1:0];
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0;
      v5 <= 1'b0; v6 <= 1'b0; v7 <= 1'b0; m_tvalid <= 1'b0;
    end else if (adv) begin
      v1 <= accept; v2 <= v1; v3 <= v2; v4 <= v3;
      v5 <= v4; v6 <= v5; v7 <= v6; m_tvalid <= v7;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (adv) begin
      eval1 <= func_in == FUNC_EVAL;
      ix0_1 <= ix[0];
      iy0_1 <= iy[0];
      offx1 <= {off_x1, off_x0};
      offy1 <= {off_y1, off_y0};
      fx1   <= fx_in;
      fy1   <= fy_in;

      miss2 <= eval1 & miss_c;
      zero2 <= !eval1 | miss_c;
      px2   <= pxc;
      py2   <= pyc;
      ta2   <= ta_c;
      tt2   <= tt_c;
      t_2[0] <= fx1;
      t_2[1] <= fy1;

      miss3 <= miss2;
      zero3 <= zero2;
      n3    <= n_c;
      b3    <= b_c;
      t3p3  <= t3p_c;

      miss4 <= miss3;
      zero4 <= zero3;
      n4    <= n3;
      sp4   <= sp_c;

      miss5 <= miss4;
      zero5 <= zero4;
      e5    <= e_c;
      sy5   <= s_c[1];
      omsy5 <= oms_c[1];

      miss6 <= miss5;
      zero6 <= zero5;
      nx6   <= nx_c;
      sy6   <= sy5;
      omsy6 <= omsy5;

      miss7 <= miss6;
      zero7 <= zero6;
      q7    <= q_c;

      m_tdata <= zero7 ? '0 : noise_c;
      m_tuser <= miss7;
    end
  end

endmodule
`default_nettype wire

>>> sv/gn2d_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "gradient_noise_2d_eval_core_assert.svh"
module gn2d_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          s_tready,
  input wire logic                          m_tvalid,
  input wire logic                          m_tready,
  input wire logic [gn2d_pkg::M_DATA_W-1:0] m_tdata,  // noise_value
  input wire logic                          m_tuser   // missing_gradient
);
  import gn2d_pkg::*;

  `GN2D_ASSERT_NXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))
  `GN2D_ASSERT_IMP(a_miss_zero, clk, rst, m_tvalid && m_tuser, m_tdata == M_DATA_W'(0))
  `GN2D_ASSERT_IMP(a_ready_room, clk, rst, s_tready, !m_tvalid || m_tready)
  `GN2D_ASSERT_IMP(a_clear_after_rst, clk, rst, $past(rst), !s_tready)

endmodule

bind gradient_noise_2d_eval_core gn2d_checker u_gn2d_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
`default_nettype wire

>>> sim/gradient_noise_2d_eval_core_tb.sv
`timescale 1ns / 1ps
module gradient_noise_2d_eval_core_tb;
  import gn2d_pkg::*;

  localparam int GW = 64;
  localparam int GH = 64;
  localparam int FB = 16;
  localparam longint ONE = longint'(1) << FB;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    func_t func;
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic signed [GRAD_W-1:0] grad_x;
    logic signed [GRAD_W-1:0] grad_y;
  } sample_t;

  typedef struct packed {
    logic signed [NOISE_W-1:0] noise;
    logic missing;
  } noise_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [S_DATA_W-1:0] s_tdata = '0;
  logic s_tuser = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;
  logic m_tuser;

  gradient_noise_2d_eval_core i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  sample_t pending_samples[$];
  noise_t expected_noise[$];
  int error_count = 0;
  int cycle_count = 0;
  bit stimulus_done = 0;
  bit hold_sender = 0;

  // predictor state
  bit grid_valid[GW*GH];
  longint grid_gx[GW*GH];
  longint grid_gy[GW*GH];

  function automatic longint rnd_shift(longint v);
    return (v + (longint'(1) << (FB - 1))) >>> FB;
  endfunction

  function automatic longint fade_curve(longint t);
    longint a, b, t2, t3;
    a = FADE_B * ONE - FADE_A * t;
    b = FADE_C * ONE - rnd_shift(t * a);
    t2 = rnd_shift(t * t);
    t3 = rnd_shift(t2 * t);
    return rnd_shift(t3 * b);
  endfunction

  function automatic bit corner_ok(longint cx, longint cy);
    if (cx >= GW || cy >= GH) return 0;
    return grid_valid[cy*GW + cx];
  endfunction

  function automatic longint corner_dot(longint cx, longint cy, longint dx, longint dy);
    int k;
    k = int'(cy*GW + cx);
    return rnd_shift(grid_gx[k] * dx + grid_gy[k] * dy);
  endfunction

  function automatic noise_t predict_noise(sample_t s);
    noise_t r;
    longint ix, iy, fx, fy, n00, n10, n01, n11, sx, sy, nx0, nx1, v;
    r = '0;
    ix = s.pos_x >> FB;
    iy = s.pos_y >> FB;
    fx = s.pos_x & (ONE - 1);
    fy = s.pos_y & (ONE - 1);
    if (s.func == FUNC_WRITE) begin
      if (ix < GW && iy < GH) begin
        grid_valid[iy*GW + ix] = 1;
        grid_gx[iy*GW + ix] = longint'(s.grad_x);
        grid_gy[iy*GW + ix] = longint'(s.grad_y);
      end
      return r;
    end
    if (!corner_ok(ix, iy) || !corner_ok(ix+1, iy) || !corner_ok(ix, iy+1) ||
        !corner_ok(ix+1, iy+1)) begin
      r.missing = 1'b1;
      return r;
    end
    n00 = corner_dot(ix, iy, fx, fy);
    n10 = corner_dot(ix+1, iy, fx - ONE, fy);
    n01 = corner_dot(ix, iy+1, fx, fy - ONE);
    n11 = corner_dot(ix+1, iy+1, fx - ONE, fy - ONE);
    sx = fade_curve(fx);
    sy = fade_curve(fy);
    nx0 = rnd_shift(n00 * (ONE - sx) + n10 * sx);
    nx1 = rnd_shift(n01 * (ONE - sx) + n11 * sx);
    v = rnd_shift(nx0 * (ONE - sy) + nx1 * sy);
    if (v > SAT_MAX) v = SAT_MAX;
    if (v < SAT_MIN) v = SAT_MIN;
    r.noise = v[15:0];
    return r;
  endfunction

  // unpack an input beat
  function automatic sample_t beat_sample(logic f, logic [S_DATA_W-1:0] d);
    sample_t s;
    s.func = func_t'(f);
    s.pos_x = d[POS_W-1:0];
    s.pos_y = d[2*POS_W-1:POS_W];
    s.grad_x = d[2*POS_W+GRAD_W-1:2*POS_W];
    s.grad_y = d[2*POS_W+2*GRAD_W-1:2*POS_W+GRAD_W];
    return s;
  endfunction

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycle_count);
    error_count++;
  endtask

  function automatic sample_t make_sample(func_t f, int x, int y, int gx, int gy);
    sample_t s;
    s.func = f;
    s.pos_x = x[POS_W-1:0];
    s.pos_y = y[POS_W-1:0];
    s.grad_x = gx[15:0];
    s.grad_y = gy[15:0];
    return s;
  endfunction

  function automatic int rand_grad();
    int p;
    p = $urandom_range(0, 9);
    if (p == 0) return $urandom_range(0, 65535) - 32768;
    if (p == 1) return ($urandom_range(0, 1) ? 16384 : -16384);
    return $urandom_range(0, 32768) - 16384;
  endfunction

  function automatic int frac_val();
    int p;
    p = $urandom_range(0, 9);
    if (p == 0) return 0;
    if (p == 1) return 65535;
    if (p == 2) return 32768;
    return $urandom_range(0, 65535);
  endfunction

  // driver
  int send_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        expected_noise.push_back(predict_noise(beat_sample(s_tuser, s_tdata)));
        send_gap = gap_len();
        if (s_tuser == FUNC_EVAL && s_tdata[POS_W-1:0] == 22'h3fffff) hold_sender = 1;
      end
      if (!(s_tvalid && !s_tready)) begin
        if (send_gap > 0 || hold_sender) begin
          if (send_gap > 0) send_gap--;
          s_tvalid <= 1'b0;
        end else if (pending_samples.size() > 0) begin
          sample_t s;
          s = pending_samples.pop_front();
          s_tvalid <= 1'b1;
          s_tuser <= s.func;
          s_tdata <= {4'b0, s.grad_y, s.grad_x, s.pos_y, s.pos_x};
        end else begin
          s_tvalid <= 1'b0;
          stimulus_done = 1;
        end
      end
      if (hold_sender && expected_noise.size() == 0 && !s_tvalid) hold_sender = 0;
    end
  end

  // monitor
  int recv_gap = 0;
  always @(posedge clk) begin
    cycle_count++;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (expected_noise.size() == 0) begin
          report_mismatch("unexpected beat", m_tdata, 0);
        end else begin
          noise_t e;
          e = expected_noise.pop_front();
          if (m_tdata !== e.noise) report_mismatch("noise_value", $signed(m_tdata), e.noise);
          if (m_tuser !== e.missing) report_mismatch("missing_gradient", m_tuser, e.missing);
        end
        recv_gap = gap_len();
      end
      if (recv_gap > 0) begin
        recv_gap--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin
    int x, y, cx, cy;
    foreach (grid_valid[k]) grid_valid[k] = 0;
    // directed
    pending_samples.push_back(make_sample(FUNC_EVAL, 0, 0, 0, 0));
    pending_samples.push_back(make_sample(FUNC_WRITE, 0, 0, 16384, -16384));
    pending_samples.push_back(make_sample(FUNC_WRITE, 1 << 16, 0, -32768, 32767));
    pending_samples.push_back(make_sample(FUNC_WRITE, 0, 1 << 16, 32767, -32768));
    pending_samples.push_back(make_sample(FUNC_EVAL, 32768, 32768, 0, 0));
    pending_samples.push_back(make_sample(FUNC_WRITE, 65536 + 65535, 65536 + 65535, -16384,
                                          16384));
    pending_samples.push_back(make_sample(FUNC_EVAL, 0, 0, 0, 0));
    pending_samples.push_back(make_sample(FUNC_EVAL, 65535, 65535, 0, 0));
    pending_samples.push_back(make_sample(FUNC_EVAL, 32768, 12345, 0, 0));
    pending_samples.push_back(make_sample(FUNC_WRITE, 4194303, 4194303, -1, -1));
    pending_samples.push_back(make_sample(FUNC_WRITE, 64 << 16, 3 << 16, 100, 100));
    pending_samples.push_back(make_sample(FUNC_WRITE, 62 << 16, 62 << 16, 32767, 32767));
    pending_samples.push_back(make_sample(FUNC_WRITE, 63 << 16, 62 << 16, 32767, 32767));
    pending_samples.push_back(make_sample(FUNC_WRITE, 62 << 16, 63 << 16, 32767, 32767));
    pending_samples.push_back(make_sample(FUNC_WRITE, 63 << 16, 63 << 16, -32768, -32768));
    pending_samples.push_back(make_sample(FUNC_EVAL, (62 << 16) + 30000, (62 << 16) + 40000,
                                          0, 0));
    pending_samples.push_back(make_sample(FUNC_EVAL, (63 << 16) + 5, (62 << 16) + 5, 0, 0));
    pending_samples.push_back(make_sample(FUNC_EVAL, 4194303, 4194303, 0, 0));
    pending_samples.push_back(make_sample(FUNC_EVAL, 22'h2aaaaa, 22'h155555, 16'h5555,
                                          16'haaaa));
    // random: fill local patches then sample them, mixed with lone evals and random beats
    while (pending_samples.size() < 1020) begin
      int p;
      p = $urandom_range(0, 99);
      cx = $urandom_range(0, 63);
      cy = $urandom_range(0, 63);
      if (p < 35) begin
        for (int dy = 0; dy < 2; dy++)
          for (int dx = 0; dx < 2; dx++)
            pending_samples.push_back(make_sample(FUNC_WRITE,
              ((cx + dx) << 16) | frac_val(), ((cy + dy) << 16) | frac_val(),
              rand_grad(), rand_grad()));
        repeat ($urandom_range(1, 4))
          pending_samples.push_back(make_sample(FUNC_EVAL, (cx << 16) | frac_val(),
            (cy << 16) | frac_val(), rand_grad(), rand_grad()));
      end else if (p < 85) begin
        pending_samples.push_back(make_sample(FUNC_EVAL, (cx << 16) | frac_val(),
          (cy << 16) | frac_val(), rand_grad(), rand_grad()));
      end else begin
        x = $urandom_range(0, 4194303);
        y = $urandom_range(0, 4194303);
        pending_samples.push_back(make_sample(func_t'($urandom_range(0, 1)), x, y,
          rand_grad(), rand_grad()));
      end
      if ($urandom_range(0, 199) == 0)
        pending_samples.push_back(make_sample(FUNC_EVAL, 4194303, 0, 0, 0));
    end
    pending_samples.push_back(make_sample(FUNC_EVAL, 4194303, 1, 0, 0));
    repeat (11) @(posedge clk);
    rst <= 1'b0;
  end

  initial begin
    wait (stimulus_done && expected_noise.size() == 0 && !s_tvalid);
    repeat (40) @(posedge clk);
    if (error_count == 0 && expected_noise.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  always @(posedge clk) begin
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout at cycle %0d", cycle_count);
      $display("== FAIL ==");
      $finish;
    end
  end
endmodule
